// ===== rtl/pshc_pkg.sv =====
// shared types and constants for the ptc sensor pid heater controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pshc_pkg;

  localparam int ADC_FULL_SCALE_DEF     = 4095;
  localparam int OPEN_SENSOR_LEVEL_DEF  = 3000;
  localparam int DUTY_FULL_SCALE_DEF    = 1000;
  localparam int GAIN_FRACTION_BITS_DEF = 8;

  localparam int ADC_W        = 12;
  localparam int TEMP_W       = 11;
  localparam int TEMP_BITS    = 10;
  localparam int DUTY_W       = 10;
  localparam int GAIN_W       = 16;
  localparam int SET_W        = 10;
  localparam int OFFSET_W     = 17;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_INDEX_W  = 3;
  localparam int ERR_W        = 12;
  localparam int DERR_W       = 13;
  localparam int ESUM_W       = 18;

  localparam int SLOPE_FRAC_BITS = 8;
  localparam int TEMP_MAX        = 1023;
  localparam int OPEN_DUTY       = 200;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SET_TEMPERATURE   = 3'd0,
    REG_PROP_GAIN         = 3'd1,
    REG_INTEG_GAIN        = 3'd2,
    REG_DERIV_GAIN        = 3'd3,
    REG_INTEGRAL_LIMIT    = 3'd4,
    REG_REF_RESISTANCE    = 3'd5,
    REG_RESISTANCE_OFFSET = 3'd6,
    REG_SLOPE_RECIP       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pshc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pshc_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem <= DEN_W'(trial);
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pshc_mac.sv =====
// serial shift-add multiply-accumulate, one multiplier bit per cycle
// depends on pshc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pshc_mac #(
  parameter int MCAND_W = 29,
  parameter int MPLR_W  = 16,
  parameter int ACC_W   = 47
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pshc_pkg::mac_ctrl_t       ctrl,
  input  wire logic signed [MCAND_W-1:0] mcand,
  input  wire logic [MPLR_W-1:0]         mplr,
  output logic                           done,
  output logic signed [ACC_W-1:0]        acc
);

  localparam int CNT_W = (MPLR_W > 1) ? $clog2(MPLR_W) : 1;

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [ACC_W-1:0] mc_sh;
  logic [MPLR_W-1:0]       mp_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MPLR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      if (ctrl.clear) begin
        acc <= '0;
      end
      mc_sh <= ACC_W'(mcand);
      mp_sh <= mplr;
    end else if (busy) begin
      if (mp_sh[0]) begin
        acc <= acc + mc_sh;
      end
      mc_sh <= mc_sh <<< 1;
      mp_sh <= mp_sh >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptc_sensor_pid_heater_control_unit.sv =====
// ptc heater sensor reading and pid duty control, one word in, one word out
// open sensor words go straight to the output word; other words use the serial divider (one quotient
// bit a cycle, skipped at adc full scale) and the shared serial multiplier
// one word at a time; the next is taken once the last reaches the output register, held on m_tready
// reset: registers take their documented reset values, error sum and last error clear to zero
// depends on pshc_pkg, pshc_div, pshc_mac
`timescale 1ns / 1ps
`default_nettype none

module ptc_sensor_pid_heater_control_unit #(
  parameter int ADC_FULL_SCALE     = pshc_pkg::ADC_FULL_SCALE_DEF,
  parameter int OPEN_SENSOR_LEVEL  = pshc_pkg::OPEN_SENSOR_LEVEL_DEF,
  parameter int DUTY_FULL_SCALE    = pshc_pkg::DUTY_FULL_SCALE_DEF,
  parameter int GAIN_FRACTION_BITS = pshc_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,    // adc_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,    // temperature, duty
  output logic             m_tuser,    // sensor_present
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [pshc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pshc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FULL_W  = $clog2(ADC_FULL_SCALE + 1);
  localparam int NUM_W   = pshc_pkg::GAIN_W + FULL_W;
  localparam int MCAND_W = NUM_W + 1;
  localparam int ACC_W   = MCAND_W + pshc_pkg::GAIN_W + 2;
  localparam int OPEN_DUTY_EFF = (pshc_pkg::OPEN_DUTY < DUTY_FULL_SCALE) ?
                                 pshc_pkg::OPEN_DUTY : DUTY_FULL_SCALE;
  localparam int SAT_LSB = pshc_pkg::SLOPE_FRAC_BITS + pshc_pkg::TEMP_BITS;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DIV    = 9'b000000010,
    ST_MULT_T = 9'b000000100,
    ST_ERR    = 9'b000001000,
    ST_MAC_P  = 9'b000010000,
    ST_MAC_I  = 9'b000100000,
    ST_MAC_D  = 9'b001000000,
    ST_DUTY   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [pshc_pkg::SET_W-1:0]    set_temperature;
  logic [pshc_pkg::GAIN_W-1:0]   prop_gain;
  logic [pshc_pkg::GAIN_W-1:0]   integ_gain;
  logic [pshc_pkg::GAIN_W-1:0]   deriv_gain;
  logic [pshc_pkg::GAIN_W-1:0]   integral_limit;
  logic [pshc_pkg::GAIN_W-1:0]   ref_resistance;
  logic [pshc_pkg::OFFSET_W-1:0] resistance_offset;
  logic [pshc_pkg::GAIN_W-1:0]   slope_recip;

  logic signed [pshc_pkg::ESUM_W-1:0] error_sum;
  logic signed [pshc_pkg::ERR_W-1:0]  last_error;

  logic [NUM_W-1:0]                    num_q;
  logic [FULL_W-1:0]                   den_q;
  logic                                div_start;
  logic                                div_done;
  logic [NUM_W-1:0]                    quo;
  logic [NUM_W-1:0]                    d_q;
  logic signed [pshc_pkg::TEMP_W-1:0]  temp_q;
  logic [pshc_pkg::DUTY_W-1:0]         duty_q;
  logic                                present_q;
  logic signed [pshc_pkg::ERR_W-1:0]   err_q;
  logic signed [pshc_pkg::DERR_W-1:0]  derr_q;

  pshc_pkg::mac_ctrl_t          mac_ctrl;
  logic signed [MCAND_W-1:0]    mcand;
  logic [pshc_pkg::GAIN_W-1:0]  mplr;
  logic                         mac_done;
  logic signed [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]             acc_u;
  logic [ACC_W-1:0]             duty_shift;
  logic [ACC_W-1:0]             duty_sel;

  logic signed [pshc_pkg::ERR_W-1:0]  err;
  logic signed [pshc_pkg::ESUM_W:0]   esum_raw;
  logic signed [pshc_pkg::ESUM_W:0]   lim_pos;
  logic signed [pshc_pkg::ESUM_W:0]   lim_neg;
  logic signed [pshc_pkg::ESUM_W-1:0] esum_next;

  logic [signed'(pshc_pkg::TEMP_W)-1:0] out_temp;
  logic [pshc_pkg::DUTY_W-1:0]          out_duty;
  logic                                 out_present;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {3'b000, out_duty, out_temp};
  assign m_tuser   = out_present;

  // error, integral clamp
  assign err      = $signed({2'b00, set_temperature}) -
                    $signed({2'b00, temp_q[pshc_pkg::TEMP_BITS-1:0]});
  assign esum_raw = (pshc_pkg::ESUM_W + 1)'(error_sum) + (pshc_pkg::ESUM_W + 1)'(err);
  assign lim_pos  = $signed({3'b000, integral_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (esum_raw > lim_pos) begin
      esum_next = pshc_pkg::ESUM_W'(lim_pos);
    end else if (esum_raw < lim_neg) begin
      esum_next = pshc_pkg::ESUM_W'(lim_neg);
    end else begin
      esum_next = pshc_pkg::ESUM_W'(esum_raw);
    end
  end

  // duty from the pid sum
  assign acc_u      = acc;
  assign duty_shift = acc_u >> GAIN_FRACTION_BITS;
  assign duty_sel   = (duty_shift > ACC_W'(DUTY_FULL_SCALE)) ?
                      ACC_W'(DUTY_FULL_SCALE) : duty_shift;

  // multiplier operand select
  always_comb begin
    case (state)
      ST_MULT_T: begin
        mcand = $signed({1'b0, d_q});
        mplr  = slope_recip;
      end
      ST_MAC_P: begin
        mcand = MCAND_W'(err_q);
        mplr  = prop_gain;
      end
      ST_MAC_I: begin
        mcand = MCAND_W'(error_sum);
        mplr  = integ_gain;
      end
      ST_MAC_D: begin
        mcand = MCAND_W'(derr_q);
        mplr  = deriv_gain;
      end
      default: begin
        mcand = '0;
        mplr  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_temperature   <= pshc_pkg::SET_W'(300);
      prop_gain         <= '0;
      integ_gain        <= '0;
      deriv_gain        <= '0;
      integral_limit    <= pshc_pkg::GAIN_W'(1000);
      ref_resistance    <= pshc_pkg::GAIN_W'(1000);
      resistance_offset <= pshc_pkg::OFFSET_W'(1000);
      slope_recip       <= pshc_pkg::GAIN_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (pshc_pkg::reg_index_t'(cfg_index))
        pshc_pkg::REG_SET_TEMPERATURE:   set_temperature   <= cfg_data[pshc_pkg::SET_W-1:0];
        pshc_pkg::REG_PROP_GAIN:         prop_gain         <= cfg_data[pshc_pkg::GAIN_W-1:0];
        pshc_pkg::REG_INTEG_GAIN:        integ_gain        <= cfg_data[pshc_pkg::GAIN_W-1:0];
        pshc_pkg::REG_DERIV_GAIN:        deriv_gain        <= cfg_data[pshc_pkg::GAIN_W-1:0];
        pshc_pkg::REG_INTEGRAL_LIMIT:    integral_limit    <= cfg_data[pshc_pkg::GAIN_W-1:0];
        pshc_pkg::REG_REF_RESISTANCE:    ref_resistance    <= cfg_data[pshc_pkg::GAIN_W-1:0];
        pshc_pkg::REG_RESISTANCE_OFFSET: resistance_offset <= cfg_data;
        pshc_pkg::REG_SLOPE_RECIP:       slope_recip       <= cfg_data[pshc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      div_start  <= 1'b0;
      mac_ctrl   <= '0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      div_start <= 1'b0;
      mac_ctrl  <= '0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (32'(s_tdata[pshc_pkg::ADC_W-1:0]) >= 32'(OPEN_SENSOR_LEVEL)) begin
              temp_q    <= '1;
              present_q <= 1'b0;
              duty_q    <= pshc_pkg::DUTY_W'(OPEN_DUTY_EFF);
              state     <= ST_OUT;
            end else if (32'(s_tdata[pshc_pkg::ADC_W-1:0]) >= 32'(ADC_FULL_SCALE)) begin
              temp_q    <= pshc_pkg::TEMP_W'(pshc_pkg::TEMP_MAX);
              present_q <= 1'b1;
              state     <= ST_ERR;
            end else begin
              num_q     <= NUM_W'(ref_resistance) * NUM_W'(ADC_FULL_SCALE);
              den_q     <= FULL_W'(ADC_FULL_SCALE) -
                           FULL_W'(s_tdata[pshc_pkg::ADC_W-1:0]);
              present_q <= 1'b1;
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (quo <= NUM_W'(resistance_offset)) begin
              temp_q <= '0;
              state  <= ST_ERR;
            end else begin
              d_q            <= quo - NUM_W'(resistance_offset);
              mac_ctrl.start <= 1'b1;
              mac_ctrl.clear <= 1'b1;
              state          <= ST_MULT_T;
            end
          end
        end
        ST_MULT_T: begin
          if (mac_done) begin
            if (acc_u[ACC_W-1:SAT_LSB] != '0) begin
              temp_q <= pshc_pkg::TEMP_W'(pshc_pkg::TEMP_MAX);
            end else begin
              temp_q <= $signed({1'b0, acc_u[SAT_LSB-1:pshc_pkg::SLOPE_FRAC_BITS]});
            end
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q          <= err;
          derr_q         <= pshc_pkg::DERR_W'(err) - pshc_pkg::DERR_W'(last_error);
          error_sum      <= esum_next;
          last_error     <= err;
          mac_ctrl.start <= 1'b1;
          mac_ctrl.clear <= 1'b1;
          state          <= ST_MAC_P;
        end
        ST_MAC_P: begin
          if (mac_done) begin
            mac_ctrl.start <= 1'b1;
            state          <= ST_MAC_I;
          end
        end
        ST_MAC_I: begin
          if (mac_done) begin
            mac_ctrl.start <= 1'b1;
            state          <= ST_MAC_D;
          end
        end
        ST_MAC_D: begin
          if (mac_done) begin
            state <= ST_DUTY;
          end
        end
        ST_DUTY: begin
          if (acc_u[ACC_W-1] || acc_u == '0) begin
            duty_q <= '0;
          end else begin
            duty_q <= duty_sel[pshc_pkg::DUTY_W-1:0];
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      out_temp    <= temp_q;
      out_duty    <= duty_q;
      out_present <= present_q;
    end
  end

  pshc_div #(
    .NUM_W (NUM_W),
    .DEN_W (FULL_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_q),
    .den   (den_q),
    .done  (div_done),
    .quo   (quo)
  );

  pshc_mac #(
    .MCAND_W (MCAND_W),
    .MPLR_W  (pshc_pkg::GAIN_W),
    .ACC_W   (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .mcand (mcand),
    .mplr  (mplr),
    .done  (mac_done),
    .acc   (acc)
  );

endmodule

`default_nettype wire

// ===== tb/tb_ptc_sensor_pid_heater_control_unit.sv =====
// self-checking testbench for the ptc sensor pid heater controller: adc words in, duty words out
// a scoreboard class predicts temperature, sensor flag and duty per accepted sample
// depends on pshc_pkg and ptc_sensor_pid_heater_control_unit
`timescale 1ns / 1ps
`default_nettype none

module tb_ptc_sensor_pid_heater_control_unit;
  import pshc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_SAMPLES  = 250;
  localparam int PRESSURE_PHASE = 2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     present;
    logic [DUTY_W-1:0]        duty;
  } heater_word_t;

  class heater_scoreboard;
    logic [SET_W-1:0]         set_temp;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic [GAIN_W-1:0]        sum_limit;
    logic [GAIN_W-1:0]        ref_res;
    logic [OFFSET_W-1:0]      res_offset;
    logic [GAIN_W-1:0]        slope;
    logic signed [ESUM_W-1:0] err_sum;
    logic signed [ERR_W-1:0]  last_err;
    heater_word_t             expected[$];
    int                       failures;

    function new();
      set_temp   = 300;
      kp         = 0;
      ki         = 0;
      kd         = 0;
      sum_limit  = 1000;
      ref_res    = 1000;
      res_offset = 1000;
      slope      = 256;
      err_sum    = 0;
      last_err   = 0;
      failures   = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SET_TEMPERATURE:   set_temp   = val[SET_W-1:0];
        REG_PROP_GAIN:         kp         = val[GAIN_W-1:0];
        REG_INTEG_GAIN:        ki         = val[GAIN_W-1:0];
        REG_DERIV_GAIN:        kd         = val[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT:    sum_limit  = val[GAIN_W-1:0];
        REG_REF_RESISTANCE:    ref_res    = val[GAIN_W-1:0];
        REG_RESISTANCE_OFFSET: res_offset = val[OFFSET_W-1:0];
        REG_SLOPE_RECIP:       slope      = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [ADC_W-1:0] adc);
      heater_word_t w;
      longint       r;
      longint       t;
      longint       err;
      longint       acc;
      longint       lim;
      longint       s;
      longint       d;
      if (longint'(adc) >= OPEN_SENSOR_LEVEL_DEF) begin
        w.temperature = '1;
        w.present     = 1'b0;
        d = (OPEN_DUTY < DUTY_FULL_SCALE_DEF) ? OPEN_DUTY : DUTY_FULL_SCALE_DEF;
        w.duty        = d[DUTY_W-1:0];
      end else begin
        if (longint'(adc) >= ADC_FULL_SCALE_DEF) begin
          t = TEMP_MAX;
        end else begin
          r = (longint'(ref_res) * ADC_FULL_SCALE_DEF) / (ADC_FULL_SCALE_DEF - longint'(adc));
          if (r <= longint'(res_offset)) begin
            t = 0;
          end else begin
            t = ((r - longint'(res_offset)) * longint'(slope)) >>> SLOPE_FRAC_BITS;
            if (t > TEMP_MAX) t = TEMP_MAX;
          end
        end
        err = longint'(set_temp) - t;
        lim = longint'(sum_limit);
        acc = longint'(err_sum) + err;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        err_sum = acc[ESUM_W-1:0];
        s = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * (err - longint'(last_err));
        last_err = err[ERR_W-1:0];
        if (s <= 0) begin
          d = 0;
        end else begin
          d = s >>> GAIN_FRACTION_BITS_DEF;
          if (d > DUTY_FULL_SCALE_DEF) d = DUTY_FULL_SCALE_DEF;
        end
        w.temperature = t[TEMP_W-1:0];
        w.present     = 1'b1;
        w.duty        = d[DUTY_W-1:0];
      end
      expected.push_back(w);
    endfunction

    function void check_word(logic [23:0] data, logic present);
      heater_word_t got;
      heater_word_t want;
      got.temperature = data[TEMP_W-1:0];
      got.duty        = data[TEMP_W+DUTY_W-1:TEMP_W];
      got.present     = present;
      if (expected.size() == 0) begin
        $display("%0t unexpected word: temperature %0d present %0b duty %0d", $time,
                 got.temperature, got.present, got.duty);
        failures++;
        return;
      end
      want = expected.pop_front();
      if (got.temperature !== want.temperature) begin
        $display("%0t temperature mismatch: expected %0d actual %0d", $time,
                 want.temperature, got.temperature);
        failures++;
      end
      if (got.present !== want.present) begin
        $display("%0t sensor_present mismatch: expected %0b actual %0b", $time,
                 want.present, got.present);
        failures++;
      end
      if (got.duty !== want.duty) begin
        $display("%0t duty mismatch: expected %0d actual %0d", $time, want.duty, got.duty);
        failures++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void flag_leftovers();
      foreach (expected[i]) begin
        $display("%0t missing word: expected temperature %0d present %0b duty %0d actual none",
                 $time, expected[i].temperature, expected[i].present, expected[i].duty);
        failures++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [15:0]            s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [23:0]            m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  heater_scoreboard   sb;
  int unsigned        settings [8];
  int                 burst_left;
  bit                 hold_request;
  int                 quiet_cycles;

  ptc_sensor_pid_heater_control_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[ptc_sensor_pid_heater_control_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int unsigned mode;
    int unsigned len;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 300);
      repeat (len) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] adc);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, adc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(adc);
    burst_left--;
    @(negedge clk);
  endtask

  // stop offering, wait for all results, then load every register
  task automatic load_settings();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= settings[i][CFG_DATA_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(reg_index_t'(i), settings[i][CFG_DATA_W-1:0]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings(input bit wild);
    if (wild) begin
      foreach (settings[i]) settings[i] = $urandom;
    end else begin
      settings[REG_SET_TEMPERATURE]   = $urandom_range(0, 1023);
      settings[REG_PROP_GAIN]         = $urandom_range(0, 8192);
      settings[REG_INTEG_GAIN]        = $urandom_range(0, 512);
      settings[REG_DERIV_GAIN]        = $urandom_range(0, 4096);
      settings[REG_INTEGRAL_LIMIT]    = $urandom_range(0, 4000);
      settings[REG_REF_RESISTANCE]    = $urandom_range(200, 4000);
      settings[REG_RESISTANCE_OFFSET] = settings[REG_REF_RESISTANCE]
                                        + $urandom_range(0, settings[REG_REF_RESISTANCE]);
      settings[REG_SLOPE_RECIP]       = $urandom_range(32, 1024);
    end
  endtask

  function automatic logic [ADC_W-1:0] random_sample();
    int unsigned pick;
    int unsigned corner;
    pick = $urandom_range(0, 99);
    if (pick < 84) return ADC_W'($urandom_range(0, OPEN_SENSOR_LEVEL_DEF - 1));
    if (pick < 94) return ADC_W'($urandom_range(OPEN_SENSOR_LEVEL_DEF, 4095));
    corner = $urandom_range(0, 5);
    case (corner)
      0: return ADC_W'(0);
      1: return ADC_W'(1);
      2: return ADC_W'(OPEN_SENSOR_LEVEL_DEF - 2);
      3: return ADC_W'(OPEN_SENSOR_LEVEL_DEF - 1);
      4: return ADC_W'(OPEN_SENSOR_LEVEL_DEF);
      default: return ADC_W'(4095);
    endcase
  endfunction

  initial begin
    sb           = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SET_TEMPERATURE;
    cfg_data     = '0;
    burst_left   = 0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values, zero gains
    send_sample(ADC_W'(0));
    send_sample(ADC_W'(800));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF - 1));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF));
    send_sample(ADC_W'(4095));

    // moderate loop: saturation, negative sum, open sensor in a run
    settings[REG_SET_TEMPERATURE]   = 300;
    settings[REG_PROP_GAIN]         = 1024;
    settings[REG_INTEG_GAIN]        = 16;
    settings[REG_DERIV_GAIN]        = 256;
    settings[REG_INTEGRAL_LIMIT]    = 1000;
    settings[REG_REF_RESISTANCE]    = 1000;
    settings[REG_RESISTANCE_OFFSET] = 1000;
    settings[REG_SLOPE_RECIP]       = 256;
    load_settings();
    send_sample(ADC_W'(0));
    send_sample(ADC_W'(800));
    send_sample(ADC_W'(1100));
    send_sample(ADC_W'(3500));
    send_sample(ADC_W'(1024));
    send_sample(ADC_W'(2048));
    send_sample(ADC_W'(2730));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF - 1));
    send_sample(ADC_W'(1));

    // all registers at their maximum
    settings[REG_SET_TEMPERATURE]   = 1023;
    settings[REG_PROP_GAIN]         = 65535;
    settings[REG_INTEG_GAIN]        = 65535;
    settings[REG_DERIV_GAIN]        = 65535;
    settings[REG_INTEGRAL_LIMIT]    = 65535;
    settings[REG_REF_RESISTANCE]    = 65535;
    settings[REG_RESISTANCE_OFFSET] = 131071;
    settings[REG_SLOPE_RECIP]       = 65535;
    load_settings();
    send_sample(ADC_W'(0));
    send_sample(ADC_W'(2047));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF - 1));
    send_sample(ADC_W'(4095));
    send_sample(ADC_W'(1));

    // all registers at zero
    foreach (settings[i]) settings[i] = 0;
    load_settings();
    send_sample(ADC_W'(0));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF - 1));
    send_sample(ADC_W'(OPEN_SENSOR_LEVEL_DEF));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_settings($urandom_range(0, 3) == 0);
      load_settings();
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      repeat (PHASE_SAMPLES) send_sample(random_sample());
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("[ptc_sensor_pid_heater_control_unit] OK");
    end else begin
      $display("[ptc_sensor_pid_heater_control_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pshc_pkg.sv
rtl/pshc_div.sv
rtl/pshc_mac.sv
rtl/ptc_sensor_pid_heater_control_unit.sv
tb/tb_ptc_sensor_pid_heater_control_unit.sv
